>>> hw/rtl/urrr_pkg.sv
// shared constants for the ultrasonic round-robin ranger
package urrr_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_GAP      = 2'd0;
  localparam logic [1:0] CFG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_TRIGGER_WIDTH = 2'd2;

  // register widths
  localparam int GAP_W   = 20;
  localparam int WAIT_W  = 16;
  localparam int PULSE_W = 8;
  localparam int DIST_W  = 14;
  localparam int LINES   = 4;

  // register reset values
  localparam logic [GAP_W-1:0]   STEP_GAP_RST      = 20'd15000;
  localparam logic [WAIT_W-1:0]  ECHO_TIMEOUT_RST  = 16'd30000;
  localparam logic [PULSE_W-1:0] TRIGGER_WIDTH_RST = 8'd10;

  // counter limits and the no-reading marker
  localparam logic [GAP_W-1:0]  GAP_MAX   = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX  = '1;
  localparam logic [DIST_W-1:0] DIST_NONE = 14'd9999;

  // distance = pulse * 343 / 2000, done as pulse * MM_MULT >> MM_SHIFT;
  // exact for every pulse below MM_SAT_PULSE, which already saturates
  localparam int MM_SHIFT = 27;
  localparam int MM_MULT_W = 25;
  localparam logic [MM_MULT_W-1:0] MM_MULT = 25'd23018341;
  localparam logic [WAIT_W-1:0] MM_SAT_PULSE = 16'd58304;

  // distance vector type
  typedef logic [DIST_W-1:0] dist_t;

endpackage

>>> hw/rtl/ultrasonic_ranger_round_robin_top.sv
// round-robin trigger and echo timing for up to four ultrasonic rangers
//
// One request is one microsecond tick carrying the sampled echo lines; each
// request gives one result carrying the trigger lines, the served sensor, the
// four stored distances and the done/timeout flags. The block takes one
// request per clock and passes it through a request register, one pass of
// update logic (a single 16 x 25 constant multiply turns the echo width
// into millimetres) and a result register that frees as soon as the result
// is taken, so a stall on the result side holds the input only once both
// registers are full. The user must write configuration through the cfg
// port only while no request is in flight; the block does not enforce it.
module ultrasonic_ranger_round_robin_top
  import urrr_pkg::*;
#(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [GAP_W-1:0]        cfg_wdata,
  // request channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [LINES-1:0]        in_echo_levels,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LINES-1:0]        out_trigger_lines,
  output logic [1:0]              out_active_sensor,
  output logic [DIST_W-1:0]       out_dist_front_left,
  output logic [DIST_W-1:0]       out_dist_front_right,
  output logic [DIST_W-1:0]       out_dist_rear_left,
  output logic [DIST_W-1:0]       out_dist_rear_right,
  output logic                    out_reading_done,
  output logic                    out_reading_timed_out
);

  // phase codes
  localparam logic [1:0] PH_GAP   = 2'd0;
  localparam logic [1:0] PH_PULSE = 2'd1;
  localparam logic [1:0] PH_ECHO  = 2'd2;

  localparam logic [2:0] SENSOR_LIMIT = 3'(SENSOR_COUNT);

  // configuration registers
  logic [GAP_W-1:0]   step_gap_r;
  logic [WAIT_W-1:0]  echo_timeout_r;
  logic [PULSE_W-1:0] trigger_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_gap_r      <= STEP_GAP_RST;
      echo_timeout_r  <= ECHO_TIMEOUT_RST;
      trigger_width_r <= TRIGGER_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_GAP:      step_gap_r      <= cfg_wdata;
        CFG_ECHO_TIMEOUT:  echo_timeout_r  <= cfg_wdata[WAIT_W-1:0];
        CFG_TRIGGER_WIDTH: trigger_width_r <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: request register feeds the update, result register feeds out
  logic             req_valid_r;
  logic [LINES-1:0] req_echo_r;
  logic             out_valid_r;
  logic             out_free;
  logic             step;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!in_stall) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_echo_r <= in_echo_levels;
    end
  end

  // sensor state
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         sensor_r, sensor_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [WAIT_W-1:0]  start_r, start_nxt;
  logic [LINES-1:0]   prev_echo_r;
  dist_t              dist_r [LINES];
  dist_t              dist_nxt [LINES];

  // per-tick results
  logic [LINES-1:0]   trig;
  logic               done;
  logic               tmo;

  // echo width to millimetres
  logic [WAIT_W-1:0]           wait_inc;
  logic [WAIT_W-1:0]           width_us;
  logic [WAIT_W+MM_MULT_W-1:0] mm_prod;
  dist_t                       mm_dist;

  assign wait_inc = (wait_r < WAIT_MAX) ? wait_r + WAIT_W'(1) : wait_r;
  assign width_us = (wait_inc >= start_r) ? wait_inc - start_r : '0;
  assign mm_prod = {{MM_MULT_W{1'b0}}, width_us} * {{WAIT_W{1'b0}}, MM_MULT};
  assign mm_dist = (width_us >= MM_SAT_PULSE) ? DIST_NONE
                                              : mm_prod[MM_SHIFT +: DIST_W];

  // one tick of the ranging sequence
  always_comb begin
    logic [1:0]         ph;
    logic               started;
    logic [LINES-1:0]   sel;
    logic [PULSE_W-1:0] pcnt;
    logic [PULSE_W-1:0] width_eff;
    logic               rise;
    logic               fall;
    logic [2:0]         next_idx;

    phase_nxt  = phase_r;
    sensor_nxt = sensor_r;
    pulse_nxt  = pulse_r;
    wait_nxt   = wait_r;
    start_nxt  = start_r;
    dist_nxt   = dist_r;
    trig       = '0;
    done       = 1'b0;
    tmo        = 1'b0;

    // unused phase code behaves as gap wait
    ph = (phase_r == PH_PULSE || phase_r == PH_ECHO) ? phase_r : PH_GAP;
    started = (ph == PH_GAP) && (gap_r >= step_gap_r);
    sel = LINES'(1) << sensor_r;
    pcnt = (started ? '0 : pulse_r) + PULSE_W'(1);
    width_eff = (trigger_width_r == '0) ? PULSE_W'(1) : trigger_width_r;
    rise = (req_echo_r[sensor_r]) && !prev_echo_r[sensor_r];
    fall = !req_echo_r[sensor_r] && prev_echo_r[sensor_r];
    next_idx = {1'b0, sensor_r} + 3'd1;

    phase_nxt = started ? PH_PULSE : ph;

    if (started || ph == PH_PULSE) begin
      // trigger pulse
      trig      = sel;
      pulse_nxt = pcnt;
      if (pcnt >= width_eff || pcnt == '0) begin
        phase_nxt = PH_ECHO;
        wait_nxt  = '0;
        start_nxt = '0;
      end
    end else if (ph == PH_ECHO) begin
      // echo watch on the served sensor only
      wait_nxt = wait_inc;
      if (rise) begin
        start_nxt = wait_nxt;
      end else if (fall) begin
        dist_nxt[sensor_r] = mm_dist;
        done = 1'b1;
      end else if (wait_r >= echo_timeout_r) begin
        dist_nxt[sensor_r] = DIST_NONE;
        done = 1'b1;
        tmo  = 1'b1;
      end
      if (done) begin
        phase_nxt  = PH_GAP;
        sensor_nxt = (next_idx >= SENSOR_LIMIT) ? 2'd0 : next_idx[1:0];
      end
    end

    // ticks since the last trigger start
    if (started) begin
      gap_nxt = GAP_W'(1);
    end else if (gap_r < GAP_MAX) begin
      gap_nxt = gap_r + GAP_W'(1);
    end else begin
      gap_nxt = gap_r;
    end
  end

  // state update on each processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_GAP;
      sensor_r    <= '0;
      gap_r       <= '0;
      pulse_r     <= '0;
      wait_r      <= '0;
      start_r     <= '0;
      prev_echo_r <= '0;
      for (int i = 0; i < LINES; i++) begin
        dist_r[i] <= DIST_NONE;
      end
    end else if (step) begin
      phase_r     <= phase_nxt;
      sensor_r    <= sensor_nxt;
      gap_r       <= gap_nxt;
      pulse_r     <= pulse_nxt;
      wait_r      <= wait_nxt;
      start_r     <= start_nxt;
      prev_echo_r <= req_echo_r;
      dist_r      <= dist_nxt;
    end
  end

  // result register
  logic [LINES-1:0] out_trig_r;
  logic [1:0]       out_sensor_r;
  dist_t            out_dist_r [LINES];
  logic             out_done_r;
  logic             out_tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_trig_r   <= trig;
      out_sensor_r <= sensor_r;
      out_dist_r   <= dist_nxt;
      out_done_r   <= done;
      out_tmo_r    <= tmo;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_trigger_lines     = out_trig_r;
  assign out_active_sensor     = out_sensor_r;
  assign out_dist_front_left   = out_dist_r[0];
  assign out_dist_front_right  = out_dist_r[1];
  assign out_dist_rear_left    = out_dist_r[2];
  assign out_dist_rear_right   = out_dist_r[3];
  assign out_reading_done      = out_done_r;
  assign out_reading_timed_out = out_tmo_r;

  // at most one trigger line is driven, and only for the served sensor
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_trigger_lines))
    else $error("more than one trigger line driven");

  // a timeout is always a finished reading
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reading_timed_out |-> out_reading_done)
    else $error("timeout flagged without a finished reading");

  // the served sensor stays within the configured count
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, sensor_r} < SENSOR_LIMIT)
    else $error("sensor index beyond sensor count");

  // a timeout reading leaves the no-reading marker for the served sensor
  assert property (@(posedge clk) disable iff (!rst_n)
    step && tmo |=> dist_r[$past(sensor_r)] == DIST_NONE)
    else $error("timeout did not store the no-reading marker");

endmodule
